>>> sv/fbc_pkg.sv
// fbc_pkg: shared types, constants and register codes of the frustum box cull block.
// No dependencies. fbc_front, fbc_back and frustum_box_cull import it.

package fbc_pkg;

  // item geometry
  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned CoefWidth   = 16;
  localparam int unsigned NumPlanes   = 6;
  localparam int unsigned NumCoefs    = 4;
  localparam int unsigned PlaneWidth  = CoefWidth * NumCoefs;
  localparam int unsigned CfgIdxWidth = 3;

  // exact dot product widths: one product, then three products plus offset
  localparam int unsigned ProdWidth = CoefWidth + CoordWidth;
  localparam int unsigned SumWidth  = ProdWidth + 2;

  // coefficient slots inside one packed plane word, a lowest
  localparam int unsigned CoefA = 0;
  localparam int unsigned CoefB = 1;
  localparam int unsigned CoefC = 2;
  localparam int unsigned CoefD = 3;

  // default queue depths
  localparam int unsigned MidDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPlane0 = 3'd0,
    CfgPlane1 = 3'd1,
    CfgPlane2 = 3'd2,
    CfgPlane3 = 3'd3,
    CfgPlane4 = 3'd4,
    CfgPlane5 = 3'd5
  } cfg_idx_e;

  // one input request: a box corner
  typedef struct packed {
    logic signed [CoordWidth-1:0] corner_x;
    logic signed [CoordWidth-1:0] corner_y;
    logic signed [CoordWidth-1:0] corner_z;
    logic                         last_corner;
  } corner_t;

  // one result request: the verdict for a box
  typedef struct packed {
    logic box_outside;
    logic box_inside;
  } result_t;

  // classified corner passed from front to back
  typedef struct packed {
    logic [NumPlanes-1:0] in_bits;
    logic                 last;
  } cls_t;

endpackage

>>> sv/fbc_fifo.sv
// fbc_fifo: small synchronous queue of registers with show-ahead read.
// No dependencies. Used between front and back and on the result side.

module fbc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/fbc_front.sv
// fbc_front: plane registers and the two-stage corner classifier.
// Depends on fbc_pkg. Feeds one classified corner per cycle into the middle queue while it has room.

module fbc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [fbc_pkg::PlaneWidth-1:0]  cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  fbc_pkg::corner_t                corner_i,
  output logic                            cls_valid_o,
  input  logic                            cls_full_i,
  output fbc_pkg::cls_t                   cls_o
);

  import fbc_pkg::*;

  logic [PlaneWidth-1:0] plane_q [NumPlanes];

  // stage one: products and offsets
  logic                        s1_valid_q;
  logic                        s1_last_q;
  logic signed [ProdWidth-1:0] prod_x_q [NumPlanes];
  logic signed [ProdWidth-1:0] prod_y_q [NumPlanes];
  logic signed [ProdWidth-1:0] prod_z_q [NumPlanes];
  logic signed [CoefWidth-1:0] coef_d_q [NumPlanes];

  // stage two: per-plane in bits
  logic                 s2_valid_q;
  logic                 s2_last_q;
  logic [NumPlanes-1:0] s2_in_q;
  logic [NumPlanes-1:0] in_bits_d;
  logic signed [SumWidth-1:0] sum_w [NumPlanes];

  logic s1_ready, s2_ready, accept;

  // stall chain back from the middle queue
  assign s2_ready    = !s2_valid_q || !cls_full_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign accept      = push_i && s1_ready;
  assign full_o      = !s1_ready;
  assign cls_valid_o = s2_valid_q;
  assign cls_o       = '{in_bits: s2_in_q, last: s2_last_q};

  // plane registers, writes beyond the last plane are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPlanes; p++) begin
        plane_q[p] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= CfgPlane5)) begin
      plane_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= push_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // multiply stage, one product per coefficient a, b, c and plane, d registered as is
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= corner_i.last_corner;
      for (int p = 0; p < NumPlanes; p++) begin
        prod_x_q[p] <= ProdWidth'($signed(plane_q[p][CoefA*CoefWidth +: CoefWidth]))
                     * ProdWidth'(corner_i.corner_x);
        prod_y_q[p] <= ProdWidth'($signed(plane_q[p][CoefB*CoefWidth +: CoefWidth]))
                     * ProdWidth'(corner_i.corner_y);
        prod_z_q[p] <= ProdWidth'($signed(plane_q[p][CoefC*CoefWidth +: CoefWidth]))
                     * ProdWidth'(corner_i.corner_z);
        coef_d_q[p] <= $signed(plane_q[p][CoefD*CoefWidth +: CoefWidth]);
      end
    end
  end

  // exact sum and sign test: in when the sum is zero or negative
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      sum_w[p] = SumWidth'(prod_x_q[p]) + SumWidth'(prod_y_q[p])
               + SumWidth'(prod_z_q[p]) + SumWidth'(coef_d_q[p]);
      in_bits_d[p] = sum_w[p][SumWidth-1] || (sum_w[p] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_in_q   <= in_bits_d;
      s2_last_q <= s1_last_q;
    end
  end

endmodule

>>> sv/fbc_back.sv
// fbc_back: per-plane all-in / all-out gathering and the result queue.
// Depends on fbc_pkg and fbc_fifo. Takes classified corners from the middle queue.

module fbc_back #(
  parameter int unsigned OutDepth = fbc_pkg::OutDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_empty_i,
  input  fbc_pkg::cls_t     cls_i,
  output logic              cls_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fbc_pkg::result_t  result_o
);

  import fbc_pkg::*;

  logic [NumPlanes-1:0] all_in_q, all_in_d;
  logic [NumPlanes-1:0] all_out_q, all_out_d;
  logic [NumPlanes-1:0] new_in, new_out;
  logic                 res_full, res_push;
  result_t              res_d;
  logic [$bits(result_t)-1:0] res_rdata;

  // a last corner waits until the result queue has room
  assign cls_pop_o = !cls_empty_i && (!cls_i.last || !res_full);
  assign res_push  = cls_pop_o && cls_i.last;

  // fold this corner into the running flags
  always_comb begin
    new_in    = all_in_q & cls_i.in_bits;
    new_out   = all_out_q & ~cls_i.in_bits;
    res_d     = '{box_outside: |new_out, box_inside: &new_in};
    all_in_d  = all_in_q;
    all_out_d = all_out_q;
    if (cls_pop_o) begin
      if (cls_i.last) begin
        all_in_d  = '1;
        all_out_d = '1;
      end else begin
        all_in_d  = new_in;
        all_out_d = new_out;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_in_q  <= '1;
      all_out_q <= '1;
    end else begin
      all_in_q  <= all_in_d;
      all_out_q <= all_out_d;
    end
  end

  // result queue toward the consumer
  fbc_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_rdata),
    .empty_o (empty_o)
  );

  assign result_o = result_t'(res_rdata);

endmodule

>>> sv/frustum_box_cull.sv
// frustum_box_cull: top level of the frustum box culling block.
// Depends on fbc_pkg, fbc_fifo, fbc_front and fbc_back.

// Tests a box against six frustum planes held in plane_0..plane_5 (cfg index
// 0..5, coefficients a,b,c,d packed as signed 16-bit fields, a lowest). Push
// the box corners one per request, last_corner set on the final one; each
// corner is in for a plane when a*x+b*y+c*z+d <= 0, computed exactly. One
// result request follows each last corner: box_outside when some plane has
// every corner out, box_inside when every corner is in for every plane. The
// block takes one corner every cycle while the middle queue has room; the rate
// is set by the two-stage multiply/sum front, which runs one corner per cycle.
// A last corner passes stage one, stage two and the middle queue; its result
// then enters the result queue. Planes are read only when a corner is taken,
// so a write is used by every corner taken after its edge and needs no quiet
// cycles; corners already taken keep the planes they were classified with.

module frustum_box_cull #(
  parameter int unsigned MidDepth = fbc_pkg::MidDepthDefault,
  parameter int unsigned OutDepth = fbc_pkg::OutDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [fbc_pkg::PlaneWidth-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  fbc_pkg::corner_t                corner_i,
  output logic                            empty,
  input  logic                            pop,
  output fbc_pkg::result_t                result_o
);

  import fbc_pkg::*;

  logic                    cls_valid, mid_full, mid_empty, mid_pop;
  cls_t                    cls_w, mid_head;
  logic [$bits(cls_t)-1:0] mid_rdata;

  // front: plane registers and classifier
  fbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .corner_i    (corner_i),
    .cls_valid_o (cls_valid),
    .cls_full_i  (mid_full),
    .cls_o       (cls_w)
  );

  // middle queue between front and back
  fbc_fifo #(
    .Width ($bits(cls_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_valid),
    .data_i  (cls_w),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_head = cls_t'(mid_rdata);

  // back: flag gathering and result queue
  fbc_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_empty_i (mid_empty),
    .cls_i       (mid_head),
    .cls_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

  // a box can never be both fully inside and outside
  a_verdict_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.box_outside && result_o.box_inside))
    else $error("box reported both inside and outside");

  // the front only stalls when the middle queue is backed up
  a_full_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> mid_full)
    else $error("front stalled without a full middle queue");

  // the back never reads an empty middle queue
  a_mid_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back popped an empty middle queue");

endmodule
